// ----- design/tbpd_pkg.sv -----
// Package for the text/binary packet deframer.
// Holds the receive mode type, the result record, queue sizing and register indexes.
// No dependencies; compiled first.
package tbpd_pkg;

	localparam int MAX_PACKET_LEN = 4096;
	localparam int CNT_W = $clog2(MAX_PACKET_LEN + 1);
	localparam int LEN_W = 13;
	localparam int TERM_W = 32;
	localparam int WIN_W = 24;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] TERM_RESET = 32'h0A0D_0A0D;
	localparam logic [7:0] START_RESET = 8'h00;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_BHDR  = 2'd1,
		MODE_BDATA = 2'd2,
		MODE_TEXT  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 8'd0,
		REG_TERMINATOR = 8'd1
	} cfg_reg_t;

	typedef enum logic {
		KIND_TEXT   = 1'b0,
		KIND_BINARY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             has_byte;
		logic             packet_kind;
		logic             packet_end;
		logic [LEN_W-1:0] packet_length;
		logic             overflow;
	} res_t;

	// Write request from front to back
	typedef struct packed {
		logic valid;
		res_t res;
	} q_wr_t;

	// Queue status returned to the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- design/tbpd_if.sv -----
// Channel interfaces for the deframer: input bytes, results and register writes.
// Depends on tbpd_pkg for widths.
interface tbpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tbpd_out_if;
	import tbpd_pkg::*;
	logic             valid;
	logic             ready;
	logic [7:0]       out_byte;
	logic             has_byte;
	logic             packet_kind;
	logic             packet_end;
	logic [LEN_W-1:0] packet_length;
	logic             overflow;

	modport source (output valid, output out_byte, output has_byte, output packet_kind,
		output packet_end, output packet_length, output overflow, input ready);
	modport sink (input valid, input out_byte, input has_byte, input packet_kind,
		input packet_end, input packet_length, input overflow, output ready);
endinterface

interface tbpd_cfg_if;
	import tbpd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/tbpd_front.sv -----
// Front end of the deframer: accepts bytes, tracks packet framing and builds result items.
// Depends on tbpd_pkg and tbpd_if; pushes results into the back-end queue.
module tbpd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	tbpd_in_if.sink                  in_ch,
	input  logic [7:0]               start_byte,
	input  logic [31:0]              terminator,
	input  tbpd_pkg::q_stat_t        q_stat,
	output tbpd_pkg::q_wr_t          q_wr
);
	import tbpd_pkg::*;

	mode_t              mode_q, mode_d;
	logic [1:0]         hdr_q, hdr_d;
	logic [31:0]        len_q, len_d;
	logic [WIN_W-1:0]   win_q, win_d;
	logic [1:0]         fill_q, fill_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               ovf_q, ovf_d;

	logic               accept;
	logic [7:0]         b;
	logic [31:0]        len_asm;
	logic               cnt_sat;
	logic [CNT_W-1:0]   cnt_inc;
	logic               ovf_inc;
	logic               term_hit;
	res_t               res;
	logic               push;

	// Accept while the queue has room
	assign in_ch.ready = !q_stat.full;
	assign accept = in_ch.valid && in_ch.ready;
	assign b = in_ch.in_byte;

	// Shared arithmetic
	assign len_asm = len_q | (32'(b) << {hdr_q, 3'b000});
	assign cnt_sat = (32'(cnt_q) >= 32'(MAX_PACKET_LEN));
	assign cnt_inc = cnt_sat ? cnt_q : cnt_q + CNT_W'(1);
	assign ovf_inc = ovf_q | cnt_sat;
	assign term_hit = ({b, win_q} == terminator);

	// Next receive mode
	always_comb begin
		mode_d = mode_q;
		if (accept) begin
			unique case (mode_q)
				MODE_IDLE: mode_d = (b == start_byte) ? MODE_BHDR : MODE_TEXT;
				MODE_BHDR: begin
					if (hdr_q == 2'd3) begin
						mode_d = (len_asm == 32'd0) ? MODE_IDLE : MODE_BDATA;
					end
				end
				MODE_BDATA: begin
					if (len_q == 32'd1) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_TEXT: begin
					if (fill_q == 2'd3 && term_hit) begin
						mode_d = MODE_IDLE;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
	end

	// Datapath updates and result item
	always_comb begin
		hdr_d = hdr_q;
		len_d = len_q;
		win_d = win_q;
		fill_d = fill_q;
		cnt_d = cnt_q;
		ovf_d = ovf_q;
		push = 1'b0;
		res = '0;
		if (accept) begin
			unique case (mode_q)
				MODE_IDLE: begin
					// open a new packet; a text packet keeps this byte as its first
					hdr_d = 2'd0;
					len_d = 32'd0;
					cnt_d = '0;
					ovf_d = 1'b0;
					win_d = '0;
					fill_d = 2'd0;
					if (b != start_byte) begin
						win_d = WIN_W'(b);
						fill_d = 2'd1;
					end
				end
				MODE_BHDR: begin
					len_d = len_asm;
					hdr_d = hdr_q + 2'd1;
					if (hdr_q == 2'd3 && len_asm == 32'd0) begin
						push = 1'b1;
						res.packet_kind = KIND_BINARY;
						res.packet_end = 1'b1;
					end
				end
				MODE_BDATA: begin
					cnt_d = cnt_inc;
					ovf_d = ovf_inc;
					len_d = len_q - 32'd1;
					push = 1'b1;
					res.out_byte = b;
					res.has_byte = 1'b1;
					res.packet_kind = KIND_BINARY;
					if (len_q == 32'd1) begin
						res.packet_end = 1'b1;
						res.packet_length = LEN_W'(cnt_inc);
						res.overflow = ovf_inc;
					end
				end
				MODE_TEXT: begin
					if (fill_q != 2'd3) begin
						// fill the look-behind window
						win_d = win_q | (WIN_W'(b) << {fill_q, 3'b000});
						fill_d = fill_q + 2'd1;
					end else if (term_hit) begin
						// drop held terminator bytes, emit end marker
						push = 1'b1;
						res.packet_kind = KIND_TEXT;
						res.packet_end = 1'b1;
						res.packet_length = LEN_W'(cnt_q);
						res.overflow = ovf_q;
						win_d = '0;
						fill_d = 2'd0;
					end else begin
						// release the oldest held byte
						cnt_d = cnt_inc;
						ovf_d = ovf_inc;
						push = 1'b1;
						res.out_byte = win_q[7:0];
						res.has_byte = 1'b1;
						res.packet_kind = KIND_TEXT;
						win_d = {b, win_q[WIN_W-1:8]};
					end
				end
				default: ;
			endcase
		end
	end

	assign q_wr.valid = push;
	assign q_wr.res = res;

	// Hold framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hdr_q <= 2'd0;
			len_q <= 32'd0;
			win_q <= '0;
			fill_q <= 2'd0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			hdr_q <= hdr_d;
			len_q <= len_d;
			win_q <= win_d;
			fill_q <= fill_d;
			cnt_q <= cnt_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

// ----- design/tbpd_back.sv -----
// Back end of the deframer: a short result queue that drives the output channel.
// Depends on tbpd_pkg and tbpd_if; filled by tbpd_front.
module tbpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tbpd_pkg::q_wr_t   q_wr,
	output tbpd_pkg::q_stat_t q_stat,
	tbpd_out_if.source        out_ch
);
	import tbpd_pkg::*;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               pop;
	res_t               head;

	assign pop = out_ch.valid && out_ch.ready;
	assign q_stat.full = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// Store pushed items
	always_ff @(posedge clk) begin
		if (q_wr.valid) begin
			mem_q[wr_ptr_q] <= q_wr.res;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (q_wr.valid) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (q_wr.valid && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (!q_wr.valid && pop) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	// Present the head item
	assign head = mem_q[rd_ptr_q];
	assign out_ch.valid = !q_stat.empty;
	assign out_ch.out_byte = head.out_byte;
	assign out_ch.has_byte = head.has_byte;
	assign out_ch.packet_kind = head.packet_kind;
	assign out_ch.packet_end = head.packet_end;
	assign out_ch.packet_length = head.packet_length;
	assign out_ch.overflow = head.overflow;

endmodule

// ----- design/text_binary_packet_deframer.sv -----
// Top level of the text/binary packet deframer.
// Depends on tbpd_pkg, tbpd_if, tbpd_front and tbpd_back.
//
// Usage:
//   in_ch  : one received byte per item (valid/ready).
//   out_ch : zero or one result per input byte: a payload byte (has_byte=1)
//            or an end marker; packet_end flags the last result of a packet,
//            with packet_length and overflow valid on it.
//   cfg_ch : register writes, index 0 = binary start byte, index 1 = text
//            terminator (first byte in bits 7:0). Other indexes are ignored.
//            Always ready; write only while the block is idle.
// Throughput: one byte per cycle while the queue has room. The front end
//   registers framing state; results wait in order in a four-entry queue.
// Holding: text bytes are held three bytes deep until they cannot start the
//   terminator.
// Reset: arst_n clears framing state and the queue, and loads the register
//   defaults (start byte 0x00, terminator 0x0A0D0A0D).
// Stall: while out_ch is stalled the queue keeps filling; in_ch.ready drops
//   only when the queue is full.
module text_binary_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	tbpd_in_if.sink     in_ch,
	tbpd_out_if.source  out_ch,
	tbpd_cfg_if.sink    cfg_ch
);
	import tbpd_pkg::*;

	logic [7:0]  start_byte_q;
	logic [31:0] terminator_q;
	q_wr_t       q_wr;
	q_stat_t     q_stat;

	// Register writes
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_RESET;
			terminator_q <= TERM_RESET;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			if (cfg_ch.index == REG_START_BYTE) begin
				start_byte_q <= cfg_ch.data[7:0];
			end else if (cfg_ch.index == REG_TERMINATOR) begin
				terminator_q <= cfg_ch.data[TERM_W-1:0];
			end
		end
	end

	tbpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.start_byte (start_byte_q),
		.terminator (terminator_q),
		.q_stat     (q_stat),
		.q_wr       (q_wr)
	);

	tbpd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_stat (q_stat),
		.out_ch (out_ch)
	);

endmodule

// ----- design/tbpd_checks.sv -----
// Port-level checks for the deframer output channel, bound to the top level.
// Depends on tbpd_pkg and the text_binary_packet_deframer ports.
module tbpd_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [7:0]                 out_byte,
	input logic                       has_byte,
	input logic                       packet_kind,
	input logic                       packet_end,
	input logic [tbpd_pkg::LEN_W-1:0] packet_length,
	input logic                       overflow
);
	import tbpd_pkg::*;

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// End markers close a packet and carry no byte
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> packet_end && out_byte == 8'd0)
		else $error("end marker malformed");

	// Length and overflow only on the last result
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_end |-> packet_length == '0 && !overflow)
		else $error("length shown before packet end");

	// A text packet ends with a marker, never a byte
	a_text_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_end && packet_kind == KIND_TEXT |-> !has_byte)
		else $error("text packet ended on a byte");

endmodule

bind text_binary_packet_deframer tbpd_checks u_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_byte      (out_ch.out_byte),
	.has_byte      (out_ch.has_byte),
	.packet_kind   (out_ch.packet_kind),
	.packet_end    (out_ch.packet_end),
	.packet_length (out_ch.packet_length),
	.overflow      (out_ch.overflow)
);
